/* rtl/ssc_pkg.sv */
package ssc_pkg;
   localparam int unsigned NUM_REGS = 3;
   localparam logic [1:0] REG_MODULUS_P   = 2'd0;
   localparam logic [1:0] REG_ORDER_Q     = 2'd1;
   localparam logic [1:0] REG_GENERATOR_G = 2'd2;

   // modular unit operation select
   typedef enum logic [1:0] {
      OP_MULMOD = 2'd0,  // (a * b) mod m
      OP_REDUCE = 2'd1   // a mod m
   } op_type;
endpackage

/* rtl/ssc_if.sv */
interface ssc_req_if #(parameter int unsigned WORD_BITS = 31);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] public_key;
   logic [WORD_BITS-1:0] message;
   logic [WORD_BITS-1:0] commitment;
   logic [WORD_BITS-1:0] response;
   modport source (output valid, public_key, message, commitment, response, input ready);
   modport sink   (input valid, public_key, message, commitment, response, output ready);
endinterface

interface ssc_rsp_if;
   logic valid;
   logic ready;
   logic valid_res;
   modport source (output valid, valid_res, input ready);
   modport sink   (input valid, valid_res, output ready);
endinterface

/* rtl/ssc_modmul.sv */
// Bit-serial (a * b) mod m, one multiplier bit per cycle, MSB first.
// a is reduced below m in the first cycles (a may be up to 2*W bits).
module ssc_modmul #(
   parameter int unsigned W = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [2*W-1:0]   a,
   input  logic [W:0]       b,
   input  logic [W:0]       m,
   output logic             done,
   output logic [W:0]       result
);
   localparam int unsigned AW = 2 * W;
   localparam int unsigned CW = $clog2(AW + W + 2) + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RED  = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] a_ff, a_in;       // shifted-out source bits for reduce
   logic [W:0]    b_ff, b_in;
   logic [W:0]    ar_ff, ar_in;     // reduced a
   logic [W+1:0]  acc_ff, acc_in;
   logic          done_ff, done_in;

   logic [W+2:0] dbl;
   logic [W+2:0] dbl2;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      ar_in    = ar_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      dbl      = '0;
      dbl2     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               a_in     = a;
               b_in     = b;
               acc_in   = '0;
               cnt_in   = CW'(AW);
               state_in = S_RED;
            end
         end
         S_RED: begin
            // acc = (2*acc + next bit of a) mod m
            dbl = {acc_ff, a_ff[AW-1]};
            if (dbl >= {2'b00, m}) dbl = dbl - {2'b00, m};
            acc_in = dbl[W+1:0];
            a_in   = {a_ff[AW-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               ar_in    = dbl[W:0];
               acc_in   = '0;
               cnt_in   = CW'(W + 1);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // acc = (2*acc + bit*ar) mod m, two conditional subtracts
            dbl = {acc_ff, 1'b0};
            if (dbl >= {2'b00, m}) dbl = dbl - {2'b00, m};
            dbl2 = dbl + (b_ff[W] ? {2'b00, ar_ff} : '0);
            if (dbl2 >= {2'b00, m}) dbl2 = dbl2 - {2'b00, m};
            acc_in = dbl2[W+1:0];
            b_in   = {b_ff[W-1:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      ar_ff  <= ar_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff[W:0];
endmodule

/* rtl/schnorr_signature_check.sv */
// Schnorr signature check, toy challenge e = (R + m) mod q.
// Channels: req (public_key, message, commitment, response) in, rsp (valid_res) out,
// both valid/ready; a beat moves when valid and ready are high at a clock edge.
// csr_we/csr_index/csr_wdata write p (0), q (1), g (2); write only while idle.
// One request at a time: req_ready is high only when the sequencer is idle
// and no result is pending. All modular operations share a single bit-serial
// modular multiplier. Per item: a reduction for e when q is nonzero, a base
// reduction per power, square-and-multiply over the exponent bits (up to 31
// multiplies and 31 squares for g^s, 32 and 31 for y^e), and a final R*y^e
// mod p: at most 128 operations.
// If p is zero no arithmetic runs and the result beat carries a low flag.
// Reset (synchronous, high) loads p=23, q=11, g=4 and empties the block.
// When rsp_ready is low the result beat holds and no new request is taken.
module schnorr_signature_check #(
   parameter int unsigned WORD_BITS = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   ssc_req_if.sink              req,
   ssc_rsp_if.source            rsp,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [WORD_BITS-1:0] csr_wdata
);
   localparam int unsigned W  = WORD_BITS;
   localparam int unsigned EB = 33;   // exponent bits walked
   localparam int unsigned EW = $clog2(EB + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_E     = 4'd1;   // e = (R+m) mod q
   localparam logic [3:0] S_PRE   = 4'd2;   // reduce bases
   localparam logic [3:0] S_PREW  = 4'd3;
   localparam logic [3:0] S_STEP  = 4'd4;   // acc*b if bit
   localparam logic [3:0] S_STEPW = 4'd5;
   localparam logic [3:0] S_SQ    = 4'd6;   // b*b
   localparam logic [3:0] S_SQW   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;   // R * y^e
   localparam logic [3:0] S_FINW  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;
   localparam logic [3:0] S_EW    = 4'd11;

   // configuration registers
   logic [W-1:0] p_ff, q_ff, g_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= W'(23);
         q_ff <= W'(11);
         g_ff <= W'(4);
      end else if (csr_we) begin
         unique case (csr_index)
            ssc_pkg::REG_MODULUS_P:   p_ff <= csr_wdata;
            ssc_pkg::REG_ORDER_Q:     q_ff <= csr_wdata;
            ssc_pkg::REG_GENERATOR_G: g_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [3:0]    state_ff, state_in;
   logic          pass_ff, pass_in;     // 0: g^s, 1: y^e
   logic [EW-1:0] bit_ff, bit_in;
   logic [W:0]    y_ff, y_in, r_ff, r_in, s_ff, s_in;
   logic [W:0]    e_ff, e_in;           // exponent (32 bits when q is 0)
   logic [W:0]    base_ff, base_in, acc_ff, acc_in, lhs_ff, lhs_in;
   logic          res_ff, res_in;
   logic          rv_ff, rv_in;

   // shared unit
   logic             mm_start;
   logic [2*W-1:0]   mm_a;
   logic [W:0]       mm_b, mm_m;
   logic             mm_done;
   logic [W:0]       mm_res;

   ssc_modmul #(.W(W)) u_mul (
      .clock (clock), .reset (reset), .start (mm_start),
      .a (mm_a), .b (mm_b), .m (mm_m), .done (mm_done), .result (mm_res)
   );

   logic [W:0] exp_cur;
   logic [W:0] one_mod;
   assign exp_cur = pass_ff ? e_ff : s_ff;
   assign one_mod = (p_ff == W'(1)) ? '0 : (W+1)'(1);

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      bit_in   = bit_ff;
      y_in     = y_ff;
      r_in     = r_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      lhs_in   = lhs_ff;
      res_in   = res_ff;
      rv_in    = rv_ff;
      mm_start = 1'b0;
      mm_a     = '0;
      mm_b     = (W+1)'(1);
      mm_m     = {1'b0, p_ff};
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && !rv_ff) begin
               y_in = {1'b0, req.public_key};
               r_in = {1'b0, req.commitment};
               s_in = {1'b0, req.response};
               e_in = {1'b0, req.commitment} + {1'b0, req.message};
               if (p_ff == '0) begin
                  res_in   = 1'b0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_E;
               end
            end
         end
         S_E: begin
            if (q_ff == '0) begin
               state_in = S_PRE;
            end else begin
               mm_start = 1'b1;
               mm_a     = (2*W)'(e_ff);
               mm_m     = {1'b0, q_ff};
               state_in = S_EW;
            end
         end
         S_EW: begin
            mm_m = {1'b0, q_ff};
            if (mm_done) begin
               e_in     = mm_res;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            mm_start = 1'b1;
            mm_a     = (2*W)'(pass_ff ? y_ff : {1'b0, g_ff});
            acc_in   = one_mod;
            bit_in   = '0;
            state_in = S_PREW;
         end
         S_PREW: begin
            if (mm_done) begin
               base_in  = mm_res;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (bit_ff < EW'(W + 1) && exp_cur[bit_ff[$clog2(W+1)-1:0]]) begin
               mm_start = 1'b1;
               mm_a     = (2*W)'(acc_ff);
               mm_b     = base_ff;
               state_in = S_STEPW;
            end else begin
               state_in = S_SQ;
            end
         end
         S_STEPW: begin
            if (mm_done) begin
               acc_in   = mm_res;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (bit_ff == EW'(EB - 1)) begin
               // last step: square unused
               if (!pass_ff) begin
                  lhs_in   = acc_ff;
                  pass_in  = 1'b1;
                  state_in = S_PRE;
               end else begin
                  pass_in  = 1'b0;
                  state_in = S_FIN;
               end
            end else if (bit_ff >= EW'(W)) begin
               bit_in   = bit_ff + 1'b1;
               state_in = S_STEP;
            end else begin
               mm_start = 1'b1;
               mm_a     = (2*W)'(base_ff);
               mm_b     = base_ff;
               state_in = S_SQW;
            end
         end
         S_SQW: begin
            if (mm_done) begin
               base_in  = mm_res;
               bit_in   = bit_ff + 1'b1;
               state_in = S_STEP;
            end
         end
         S_FIN: begin
            mm_start = 1'b1;
            mm_a     = (2*W)'(r_ff);
            mm_b     = acc_ff;
            state_in = S_FINW;
         end
         S_FINW: begin
            if (mm_done) begin
               res_in   = (mm_res == lhs_ff);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rv_ff) begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= 1'b0;
         bit_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         bit_ff   <= bit_in;
         rv_ff    <= rv_in;
      end
      y_ff    <= y_in;
      r_ff    <= r_in;
      s_ff    <= s_in;
      e_ff    <= e_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      lhs_ff  <= lhs_in;
      res_ff  <= res_in;
   end

   assign req.ready     = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid     = rv_ff;
   assign rsp.valid_res = res_ff;
endmodule

/* dv/testbench.sv */
module testbench;

   localparam int unsigned W = 31;
   localparam logic [W-1:0] WORD_MAX = {W{1'b1}};
   // no beat on either channel for this many cycles means the block hung;
   // the limit must exceed the longest item and the long receiver hold
   localparam int unsigned HANG_LIMIT = 200000;
   localparam int unsigned LONG_HOLD = 30000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [W-1:0] csr_wdata;

   ssc_req_if #(.WORD_BITS(W)) req_ch ();
   ssc_rsp_if rsp_ch ();

   schnorr_signature_check #(.WORD_BITS(W)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // shadow copies of the group parameters
   logic [W-1:0] mod_p;
   logic [W-1:0] ord_q;
   logic [W-1:0] gen_g;

   bit verdict_q[$];       // expected valid_res flags, oldest first
   int unsigned errors;
   int unsigned quiet_cycles;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned hold_left;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // arithmetic of the check
   // ---------------------------------------------------------------
   function automatic longint unsigned pow_mod(longint unsigned base,
                                               longint unsigned ex,
                                               longint unsigned md);
      longint unsigned acc;
      longint unsigned b;
      acc = 1 % md;
      b = base % md;
      for (int i = 0; i < 33; i++) begin
         if (ex[i])
            acc = (acc * b) % md;
         b = (b * b) % md;
      end
      return acc;
   endfunction

   // g^s == R * y^e (mod p), e = (R + m) mod q
   function automatic bit signature_holds(logic [W-1:0] y, logic [W-1:0] m,
                                          logic [W-1:0] r, logic [W-1:0] s);
      longint unsigned p;
      longint unsigned e;
      longint unsigned lhs;
      longint unsigned rhs;
      p = 64'(mod_p);
      if (p == 0)
         return 1'b0;           // zero modulus: no arithmetic, flag low
      e = 64'(r) + 64'(m);      // 32-bit sum, kept whole if q is zero
      if (ord_q != 0)
         e = e % 64'(ord_q);
      lhs = pow_mod(64'(gen_g), 64'(s), p);
      rhs = (64'(r) * pow_mod(64'(y), e, p)) % p;
      return lhs == rhs;
   endfunction

   // ---------------------------------------------------------------
   // request monitor, result checker, watchdog (all at rising edge)
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         verdict_q.push_back(signature_holds(req_ch.public_key, req_ch.message,
                                             req_ch.commitment, req_ch.response));
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (verdict_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual valid_res=%0b",
                     $time, rsp_ch.valid_res);
         end else begin
            if (rsp_ch.valid_res !== verdict_q[0]) begin
               errors++;
               $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                        $time, verdict_q[0], rsp_ch.valid_res);
            end
            void'(verdict_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: long hold when asked, otherwise random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------
   task automatic send_item(logic [W-1:0] y, logic [W-1:0] m,
                            logic [W-1:0] r, logic [W-1:0] s);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         while ($urandom_range(99) < send_idle_pct)
            @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.public_key <= y;
      req_ch.message <= m;
      req_ch.commitment <= r;
      req_ch.response <= s;
      do
         @(posedge clock);
      while (!req_ch.ready);
   endtask

   // stop offering and wait for every outstanding result beat
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         ssc_pkg::REG_MODULUS_P: mod_p = value;
         ssc_pkg::REG_ORDER_Q:   ord_q = value;
         default:                gen_g = value;
      endcase
   endtask

   task automatic set_group(logic [W-1:0] p, logic [W-1:0] q, logic [W-1:0] g);
      drain();
      write_reg(ssc_pkg::REG_MODULUS_P, p);
      write_reg(ssc_pkg::REG_ORDER_Q, q);
      write_reg(ssc_pkg::REG_GENERATOR_G, g);
   endtask

   // honest signature under the current group: y = g^x, R = g^k, s = k + x*e mod q
   task automatic make_signature(output logic [W-1:0] y, output logic [W-1:0] m,
                                 output logic [W-1:0] r, output logic [W-1:0] s);
      longint unsigned x;
      longint unsigned k;
      longint unsigned e;
      x = 64'($urandom_range(32'(ord_q) - 1, 1));
      k = 64'($urandom_range(32'(ord_q) - 1, 1));
      m = W'($urandom);
      y = W'(pow_mod(64'(gen_g), x, 64'(mod_p)));
      r = W'(pow_mod(64'(gen_g), k, 64'(mod_p)));
      e = (64'(r) + 64'(m)) % 64'(ord_q);
      s = W'((k + x * e) % 64'(ord_q));
   endtask

   // mostly honest signatures, some tampered by one bit, some pure noise
   task automatic send_random(int unsigned count);
      logic [W-1:0] y, m, r, s;
      int unsigned pick;
      int unsigned bit_pos;
      repeat (count) begin
         pick = $urandom_range(99);
         make_signature(y, m, r, s);
         bit_pos = $urandom_range(W - 1);
         if (pick >= 75) begin
            y = W'($urandom); m = W'($urandom); r = W'($urandom); s = W'($urandom);
         end else if (pick >= 60) begin
            case ($urandom_range(3))
               0: y[bit_pos] = ~y[bit_pos];
               1: m[bit_pos] = ~m[bit_pos];
               2: r[bit_pos] = ~r[bit_pos];
               default: s[bit_pos] = ~s[bit_pos];
            endcase
         end
         send_item(y, m, r, s);
      end
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      logic [W-1:0] y, m, r, s;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      // reset group p=23, q=11, g=4
      send_item('0, '0, '0, '0);
      send_item(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      make_signature(y, m, r, s);
      send_item(y, m, r, s);
      send_item(y, m, r, s ^ 31'd1);            // tampered response
      send_item(y + 31'd23, m, r, s);            // key not below p
      send_item(y, m, r + 31'd23, s);            // commitment not below p
      send_item(31'd5, 31'd10, 31'd1, '0);       // zero exponents on both sides
      send_item('0, 31'd3, 31'd2, 31'd4);        // zero key
      // degenerate moduli
      set_group(31'd1, 31'd11, 31'd4);
      send_item(31'd7, 31'd9, 31'd3, 31'd5);
      send_item(WORD_MAX, '0, WORD_MAX, '0);
      set_group('0, 31'd11, 31'd4);
      send_item('0, '0, '0, '0);
      send_item(31'd18, 31'd7, 31'd12, 31'd7);
      // zero order: challenge is the raw 32-bit sum
      set_group(31'd23, '0, 31'd4);
      send_item(31'd18, WORD_MAX, WORD_MAX, 31'd9);
      send_item(31'd1, 31'd100, 31'd1, 31'd3);
      // zero and unit generator
      set_group(31'd23, 31'd11, '0);
      send_item(31'd0, 31'd1, 31'd0, 31'd5);
      send_item(31'd3, 31'd1, 31'd1, '0);
      set_group(31'd23, 31'd11, 31'd1);
      send_item(31'd1, 31'd4, 31'd1, 31'd6);
      // largest group: 7 generates all of Z_p^* for p = 2^31 - 1
      set_group(WORD_MAX, WORD_MAX - 31'd1, 31'd7);
      make_signature(y, m, r, s);
      send_item(y, m, r, s);
      send_item(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      drain();
   endtask

   // each random phase runs under the group set before it and its own idling mix
   task automatic test_random(int unsigned idle_pct, int unsigned stall_pct,
                              int unsigned count);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      send_random(count);
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = LONG_HOLD;     // receiver goes quiet, block fills and stops taking
      send_random(4);
      drain();
   endtask

   task automatic test_sender_pause();
      send_idle_pct = 0;
      recv_stall_pct = 30;
      send_random(2);
      drain();                   // sender holds until all results are in
      send_random(2);
      drain();
   endtask

   initial begin
      logic [W-1:0] sub_g;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = ssc_pkg::REG_MODULUS_P;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.public_key = '0;
      req_ch.message = '0;
      req_ch.commitment = '0;
      req_ch.response = '0;
      rsp_ch.ready = 1'b0;
      hold_left = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      errors = 0;
      quiet_cycles = 0;
      mod_p = 31'd23;
      ord_q = 31'd11;
      gen_g = 31'd4;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();

      set_group(31'd23, 31'd11, 31'd4);
      test_random(0, 0, 30);

      // order-331 subgroup of Z_p^*, p = 2^31 - 1
      sub_g = W'(pow_mod(64'd7, (64'd2147483647 - 64'd1) / 64'd331, 64'd2147483647));
      set_group(WORD_MAX, 31'd331, sub_g);
      test_random(86, 0, 30);

      set_group(WORD_MAX, WORD_MAX - 31'd1, 31'd7);
      test_random(0, 86, 30);

      set_group(31'd23, 31'd11, 31'd4);
      test_random(12, 12, 22);

      test_backpressure();
      test_sender_pause();

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
